>>> rtl/badt_pkg.sv
package badt_pkg;

    localparam int ANG_W    = 16;
    localparam int DIST_W   = 14;
    localparam int RAD_W    = 5;
    localparam int CORD_W   = 20;
    localparam int SIN_W    = 17;
    localparam int NUM_W    = RAD_W + 20;
    localparam int ITER_W   = 5;
    localparam int CORD_ITERS = 16;
    localparam int DIV_ITERS  = NUM_W;

    localparam logic signed [ANG_W-1:0] Q13_PI      = 16'sd25736;
    localparam logic [SIN_W-1:0]        Q13_HALF_PI = 17'd12868;
    localparam logic signed [CORD_W-1:0] CORD_GAIN  = 20'sd39797;
    localparam logic [DIST_W-1:0] DIST_MAX   = 14'd16383;
    localparam logic signed [15:0] SLEW_NEAR = 16'sd160;
    localparam logic signed [15:0] SLEW_FAR  = 16'sd80;

    localparam logic [1:0] REG_RADIUS  = 2'd0;
    localparam logic [1:0] REG_OUTLIER = 2'd1;
    localparam logic [1:0] REG_JUMP    = 2'd2;
    localparam logic [1:0] REG_FAR     = 2'd3;

    typedef struct packed {
        logic             ang_upd;
        logic             cord_init;
        logic             cord_step;
        logic             div_init;
        logic             div_step;
        logic             finish;
        logic [ITER_W-1:0] iter;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
    } status_t;

    function automatic logic signed [CORD_W-1:0] atan_q16(input logic [3:0] i);
        logic signed [CORD_W-1:0] v;
        case (i)
            4'd0:  v = 20'sd51472;
            4'd1:  v = 20'sd30386;
            4'd2:  v = 20'sd16055;
            4'd3:  v = 20'sd8150;
            4'd4:  v = 20'sd4091;
            4'd5:  v = 20'sd2047;
            4'd6:  v = 20'sd1024;
            4'd7:  v = 20'sd512;
            4'd8:  v = 20'sd256;
            4'd9:  v = 20'sd128;
            4'd10: v = 20'sd64;
            4'd11: v = 20'sd32;
            4'd12: v = 20'sd16;
            4'd13: v = 20'sd8;
            4'd14: v = 20'sd4;
            4'd15: v = 20'sd2;
            default: v = 20'sd0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/badt_ctrl.sv
module badt_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_xfer,
    input  badt_pkg::status_t status,
    output logic              in_ready,
    output badt_pkg::cmd_t    cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ANG   = 3'd1;
    localparam logic [2:0] S_CINIT = 3'd2;
    localparam logic [2:0] S_CORD  = 3'd3;
    localparam logic [2:0] S_DINIT = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [badt_pkg::ITER_W-1:0] cnt_reg, cnt_next;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.iter   = cnt_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_xfer) state_next = S_ANG;
            end
            S_ANG: begin
                cmd.ang_upd = 1'b1;
                state_next  = S_CINIT;
            end
            S_CINIT: begin
                cmd.cord_init = 1'b1;
                cnt_next      = '0;
                state_next    = S_CORD;
            end
            S_CORD: begin
                cmd.cord_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == badt_pkg::ITER_W'(badt_pkg::CORD_ITERS - 1))
                    state_next = S_DINIT;
            end
            S_DINIT: begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == badt_pkg::ITER_W'(badt_pkg::DIV_ITERS - 1))
                    state_next = S_FIN;
            end
            S_FIN: begin
                // wait for the output register to free up
                if (!status.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

>>> rtl/badt_dp.sv
module badt_dp (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_xfer,
    input  logic [15:0]       rise_angle,
    input  logic [15:0]       fall_angle,
    input  logic              cfg_xfer,
    input  logic [7:0]        cfg_index,
    input  logic [13:0]       cfg_data,
    input  badt_pkg::cmd_t    cmd,
    output badt_pkg::status_t status,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [15:0]       mean_angle,
    output logic              angle_valid,
    output logic [13:0]       mean_distance,
    output logic              distance_valid
);

    localparam int AW = badt_pkg::ANG_W;
    localparam int DW = badt_pkg::DIST_W;
    localparam int CW = badt_pkg::CORD_W;
    localparam int SW = badt_pkg::SIN_W;
    localparam int NW = badt_pkg::NUM_W;

    // configuration
    logic [badt_pkg::RAD_W-1:0] radius_reg;
    logic [DW-1:0] outlier_reg, jump_reg, far_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg  <= 5'd4;
            outlier_reg <= 14'd5769;
            jump_reg    <= 14'd1200;
            far_reg     <= 14'd2240;
        end else if (cfg_xfer && cfg_index[7:2] == 6'd0) begin
            case (cfg_index[1:0])
                badt_pkg::REG_RADIUS:  radius_reg  <= cfg_data[4:0];
                badt_pkg::REG_OUTLIER: outlier_reg <= cfg_data;
                badt_pkg::REG_JUMP:    jump_reg    <= cfg_data;
                badt_pkg::REG_FAR:     far_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // input capture
    logic signed [AW-1:0] rise_reg, fall_reg;
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            rise_reg <= rise_angle;
            fall_reg <= fall_angle;
        end
    end

    // angle part
    logic signed [AW:0] sum17, dif17, wdif17;
    logic signed [AW-1:0] mid, hw;
    logic wrap;

    always_comb begin
        wrap   = (rise_reg > 0) && (fall_reg < 0);
        sum17  = 17'(rise_reg) + 17'(fall_reg);
        dif17  = 17'(rise_reg) - 17'(fall_reg);
        wdif17 = dif17 - 17'sd51472;
        if (wrap) begin
            mid = -badt_pkg::Q13_PI;
            hw  = wdif17[AW:1];
        end else begin
            mid = sum17[AW:1];
            hw  = dif17[AW:1];
        end
    end

    logic signed [AW-1:0] angle_first_reg, last_angle_reg, half_width_reg;
    logic angle_phase_reg, last_angle_valid_reg;
    logic signed [AW-1:0] pend_angle_reg;
    logic pend_aok_reg;
    logic signed [AW:0] amean17;

    assign amean17 = 17'(angle_first_reg) + 17'(mid);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_first_reg      <= '0;
            last_angle_reg       <= '0;
            half_width_reg       <= 16'sd7975;
            angle_phase_reg      <= 1'b0;
            last_angle_valid_reg <= 1'b0;
        end else if (cmd.ang_upd) begin
            if (angle_phase_reg) begin
                half_width_reg  <= hw;
                angle_phase_reg <= 1'b0;
            end else begin
                angle_first_reg <= mid;
                if (!last_angle_valid_reg || last_angle_reg != mid) begin
                    angle_phase_reg      <= 1'b1;
                    last_angle_reg       <= mid;
                    last_angle_valid_reg <= 1'b1;
                    half_width_reg       <= hw;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ang_upd) begin
            pend_aok_reg   <= angle_phase_reg;
            pend_angle_reg <= angle_phase_reg ? amean17[AW:1] : '0;
        end
    end

    // cordic sine
    logic [SW-1:0] abs_hw;
    logic signed [SW-1:0] red_a;
    logic signed [CW-1:0] x_reg, y_reg, z_reg;
    logic signed [CW-1:0] x_sh, y_sh, atan_v;
    logic [3:0] sh;

    always_comb begin
        abs_hw = half_width_reg[AW-1] ? (SW'(0) - SW'(half_width_reg))
                                      : SW'(half_width_reg);
        if (abs_hw > badt_pkg::Q13_HALF_PI)
            red_a = $signed(SW'(25736)) - $signed(abs_hw);
        else
            red_a = $signed(abs_hw);
        sh     = cmd.iter[3:0];
        x_sh   = x_reg >>> sh;
        y_sh   = y_reg >>> sh;
        atan_v = badt_pkg::atan_q16(sh);
    end

    always_ff @(posedge aclk) begin
        if (cmd.cord_init) begin
            x_reg <= badt_pkg::CORD_GAIN;
            y_reg <= '0;
            z_reg <= CW'(red_a) <<< 3;
        end else if (cmd.cord_step) begin
            if (z_reg >= 0) begin
                x_reg <= x_reg - y_sh;
                y_reg <= y_reg + x_sh;
                z_reg <= z_reg - atan_v;
            end else begin
                x_reg <= x_reg + y_sh;
                y_reg <= y_reg - x_sh;
                z_reg <= z_reg + atan_v;
            end
        end
    end

    // restoring divider, radius * 2^20 / |sin|
    logic [SW-1:0] s_reg;
    logic [NW-1:0] num_reg;
    logic [SW-1:0] rem_reg;
    logic [SW:0]   r_sh, r_sub;
    logic [CW-1:0] abs_y;
    logic          qbit;

    always_comb begin
        abs_y = y_reg[CW-1] ? (CW'(0) - CW'(y_reg)) : CW'(y_reg);
        r_sh  = {rem_reg, num_reg[NW-1]};
        qbit  = (r_sh >= {1'b0, s_reg});
        r_sub = r_sh - {1'b0, s_reg};
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            s_reg   <= abs_y[SW-1:0];
            num_reg <= {radius_reg, 20'd0};
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= qbit ? r_sub[SW-1:0] : r_sh[SW-1:0];
            num_reg <= {num_reg[NW-2:0], qbit};
        end
    end

    // distance part
    logic [DW-1:0] distance_first_reg, last_distance_reg, last_mean_reg;
    logic distance_phase_reg;
    logic [DW-1:0] dist_val, dmean;
    logic [DW:0] dsum;
    logic signed [15:0] diff, prev_s, step, m1, d1, m2;
    logic [DW-1:0] mfin;
    logic jump;

    always_comb begin
        if (s_reg == '0 || num_reg > NW'(outlier_reg))
            dist_val = last_distance_reg;
        else
            dist_val = num_reg[DW-1:0];
        dsum   = {1'b0, distance_first_reg} + {1'b0, dist_val};
        dmean  = dsum[DW:1];
        prev_s = $signed({2'b00, last_mean_reg});
        diff   = $signed({2'b00, dmean}) - prev_s;
        step   = (last_mean_reg > far_reg) ? badt_pkg::SLEW_FAR : badt_pkg::SLEW_NEAR;
        jump   = (diff > $signed({2'b00, jump_reg})) ||
                 (diff < -$signed({2'b00, jump_reg}));
        m1     = jump ? prev_s : $signed({2'b00, dmean});
        d1     = jump ? 16'sd0 : diff;
        if (d1 > badt_pkg::SLEW_NEAR)
            m2 = prev_s + step;
        else if (d1 < -badt_pkg::SLEW_NEAR)
            m2 = prev_s - step;
        else
            m2 = m1;
        if (m2 < 0)
            mfin = '0;
        else if (m2 > $signed({2'b00, badt_pkg::DIST_MAX}))
            mfin = badt_pkg::DIST_MAX;
        else
            mfin = m2[DW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            distance_first_reg <= '0;
            last_distance_reg  <= 14'd16000;
            last_mean_reg      <= 14'd3200;
            distance_phase_reg <= 1'b0;
        end else if (cmd.finish) begin
            if (distance_phase_reg) begin
                last_mean_reg      <= mfin;
                distance_phase_reg <= 1'b0;
            end else begin
                distance_first_reg <= dist_val;
                if (last_distance_reg != dist_val) begin
                    distance_phase_reg <= 1'b1;
                    last_distance_reg  <= dist_val;
                end
            end
        end
    end

    // output register
    logic out_valid_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            mean_angle     <= pend_angle_reg;
            angle_valid    <= pend_aok_reg;
            mean_distance  <= distance_phase_reg ? mfin : '0;
            distance_valid <= distance_phase_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status.out_busy = out_valid_reg && !out_ready;

endmodule

>>> rtl/beacon_angle_distance_tracker_core.sv
// sequence: from the input transfer to m_tvalid the core runs an angle update, a cordic
// load, 16 cordic iterations, a divider load, 25 divide steps and a finish step
// one item in flight: a new input is taken only after the finish step; the divider
// yields one quotient bit per cycle; a stalled output holds the finish step
// reset: aresetn synchronous active low, restores registers and tracker state
module beacon_angle_distance_tracker_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // rise_angle[15:0], fall_angle[31:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // mean_angle[15:0], mean_distance[29:16], zero[31:30]
    output logic [1:0]  m_tuser,   // angle_valid[0], distance_valid[1]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [13:0] cfg_data
);

    badt_pkg::cmd_t    cmd;
    badt_pkg::status_t status;
    logic in_xfer;
    logic [15:0] mean_angle;
    logic [13:0] mean_distance;
    logic angle_valid, distance_valid;

    assign in_xfer   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    badt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_xfer  (in_xfer),
        .status   (status),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    badt_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_xfer        (in_xfer),
        .rise_angle     (s_tdata[15:0]),
        .fall_angle     (s_tdata[31:16]),
        .cfg_xfer       (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .cmd            (cmd),
        .status         (status),
        .out_ready      (m_tready),
        .out_valid      (m_tvalid),
        .mean_angle     (mean_angle),
        .angle_valid    (angle_valid),
        .mean_distance  (mean_distance),
        .distance_valid (distance_valid)
    );

    assign m_tdata = {2'b00, mean_distance, mean_angle};
    assign m_tuser = {distance_valid, angle_valid};

endmodule

>>> rtl/badt_chk.sv
module badt_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // one item in flight: input closes right after a transfer
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while busy");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_angle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[15:0] == 16'd0)
        else $error("invalid angle not zero");

    a_dist_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[1] |-> m_tdata[31:16] == 16'd0)
        else $error("invalid distance not zero");

endmodule

bind beacon_angle_distance_tracker_core badt_chk u_badt_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> test/beacon_angle_distance_tracker_core_tb.sv
`timescale 1ns / 1ps

module beacon_angle_distance_tracker_core_tb;

    typedef struct {
        logic signed [badt_pkg::ANG_W-1:0] mean_angle;
        logic                              angle_valid;
        logic [badt_pkg::DIST_W-1:0]       mean_distance;
        logic                              distance_valid;
    } track_t;

    typedef struct {
        logic signed [badt_pkg::ANG_W-1:0] rise;
        logic signed [badt_pkg::ANG_W-1:0] fall;
        bit                                typed;
        track_t                            want;
    } edge_row_t;

    localparam int IDLE_LIMIT = 3000;
    localparam longint ATAN_TBL [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024,
                                         512, 256, 128, 64, 32, 16, 8, 4, 2};

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [13:0] cfg_data;

    // tracker copy: registers and state
    logic [badt_pkg::RAD_W-1:0]  radius_q;
    logic [badt_pkg::DIST_W-1:0] outlier_q, jump_q, far_q;
    int                ang_first, last_ang, half_w;
    bit                ang_phase, last_ang_ok, dist_phase;
    longint            dist_first, last_dist, last_mean;

    track_t  tracks_due[$];
    bit      row_typed;
    track_t  row_want;
    int      send_idle_pct, recv_stall_pct;
    int      hold_off;
    int      idle_cycles;
    int      errors;

    beacon_angle_distance_tracker_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    function automatic longint abs_sine_q16(int ang);
        longint a, x, y, z, dx, dy;
        a = (ang < 0) ? -ang : ang;
        if (a > 12868) a = 25736 - a;
        z = a * 8;
        x = 39797;
        y = 0;
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN_TBL[i];
            end else begin
                x += dx; y -= dy; z += ATAN_TBL[i];
            end
        end
        return (y < 0) ? -y : y;
    endfunction

    function automatic void reset_tracker();
        radius_q = 5'd4; outlier_q = 14'd5769; jump_q = 14'd1200; far_q = 14'd2240;
        ang_first = 0; last_ang = 0; half_w = 7975;
        ang_phase = 0; last_ang_ok = 0; dist_phase = 0;
        dist_first = 0; last_dist = 16000; last_mean = 3200;
    endfunction

    function automatic void apply_reg(logic [7:0] idx, logic [13:0] val);
        case (idx)
            8'(badt_pkg::REG_RADIUS):  radius_q  = val[badt_pkg::RAD_W-1:0];
            8'(badt_pkg::REG_OUTLIER): outlier_q = val;
            8'(badt_pkg::REG_JUMP):    jump_q    = val;
            8'(badt_pkg::REG_FAR):     far_q     = val;
            default: ;
        endcase
    endfunction

    function automatic track_t track_edges(logic signed [15:0] rise, logic signed [15:0] fall);
        track_t r;
        longint mid, hw, s, q, d, m, step;
        r = '{default: '0};
        if (rise > 0 && fall < 0) begin
            mid = -25736;
            hw = (longint'(rise) - fall - 51472) >>> 1;
        end else begin
            mid = (longint'(rise) + fall) >>> 1;
            hw = (longint'(rise) - fall) >>> 1;
        end
        if (ang_phase) begin
            r.mean_angle = 16'((longint'(ang_first) + mid) >>> 1);
            r.angle_valid = 1;
            half_w = int'(hw);
            ang_phase = 0;
        end else begin
            ang_first = int'(mid);
            // a midpoint equal to the last accepted one does not start a pair
            if (!last_ang_ok || last_ang != mid) begin
                ang_phase = 1;
                last_ang = int'(mid);
                last_ang_ok = 1;
                half_w = int'(hw);
            end
        end
        s = abs_sine_q16(half_w);
        if (s == 0) begin
            d = last_dist;
        end else begin
            q = (longint'(radius_q) * 16 * 65536) / s;
            d = (q > longint'(outlier_q)) ? last_dist : q;
        end
        if (dist_phase) begin
            m = (dist_first + d) >> 1;
            step = (last_mean > far_q) ? 80 : 160;
            if (m - last_mean > longint'(jump_q) || m - last_mean < -longint'(jump_q))
                m = last_mean;
            if (m - last_mean > 160) m = last_mean + step;
            else if (m - last_mean < -160) m = last_mean - step;
            if (m < 0) m = 0;
            if (m > 16383) m = 16383;
            last_mean = m;
            r.mean_distance = 14'(m);
            r.distance_valid = 1;
            dist_phase = 0;
        end else begin
            dist_first = d;
            if (last_dist != d) begin
                dist_phase = 1;
                last_dist = d;
            end
        end
        return r;
    endfunction

    // receiver ready, with a long hold-off when asked
    always @(negedge aclk) begin
        if (hold_off > 0) begin
            m_tready <= 1'b0;
            hold_off = hold_off - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        track_t got, want;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready) begin
                want = track_edges(s_tdata[15:0], s_tdata[31:16]);
                tracks_due.push_back(row_typed ? row_want : want);
            end
            if (m_tvalid && m_tready) begin
                got.mean_angle = m_tdata[15:0];
                got.mean_distance = m_tdata[29:16];
                got.angle_valid = m_tuser[0];
                got.distance_valid = m_tuser[1];
                if (tracks_due.size() == 0) begin
                    $error("result transfer with nothing expected");
                    errors++;
                end else begin
                    want = tracks_due.pop_front();
                    if (got.mean_angle !== want.mean_angle) begin
                        $error("mean_angle expected %0d got %0d", want.mean_angle,
                               got.mean_angle);
                        errors++;
                    end
                    if (got.angle_valid !== want.angle_valid) begin
                        $error("angle_valid expected %0d got %0d", want.angle_valid,
                               got.angle_valid);
                        errors++;
                    end
                    if (got.mean_distance !== want.mean_distance) begin
                        $error("mean_distance expected %0d got %0d", want.mean_distance,
                               got.mean_distance);
                        errors++;
                    end
                    if (got.distance_valid !== want.distance_valid) begin
                        $error("distance_valid expected %0d got %0d", want.distance_valid,
                               got.distance_valid);
                        errors++;
                    end
                end
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // the typed expectation travels with the data and holds through the transfer
    task automatic send_edges(logic [15:0] rise, logic [15:0] fall, bit typed, track_t want);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        row_typed = typed;
        row_want = want;
        s_tvalid <= 1'b1;
        s_tdata <= {fall, rise};
        do @(posedge aclk); while (!(s_tvalid && s_tready));
    endtask

    task automatic write_reg(logic [7:0] idx, logic [13:0] val);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (tracks_due.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic random_edges(int count, bit pressure);
        logic signed [15:0] rise, fall, prev_rise, prev_fall;
        int hw, pick;
        track_t none;
        none = '{default: '0};
        prev_rise = 16'sd1000;
        prev_fall = 16'sd800;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            hw = $urandom_range(3000, 40);
            rise = 16'($signed($urandom_range(51472)) - 25736);
            if (pick < 50) begin
                // plausible beacon reading: narrow pulse
                fall = 16'(rise - 2 * hw);
                if (fall < -25736) fall = 16'(rise + 2 * hw);
            end else if (pick < 65) begin
                rise = prev_rise;
                fall = prev_fall;
            end else if (pick < 75) begin
                // pulse straddling the +-pi seam
                rise = 16'($urandom_range(25736, 1));
                fall = 16'(-$signed($urandom_range(25736, 1)));
            end else if (pick < 85) begin
                rise = 16'($urandom);
                fall = 16'($urandom);
            end else begin
                fall = 16'($signed($urandom_range(51472)) - 25736);
            end
            if (pressure && n == count / 2) hold_off = 800;
            send_edges(rise, fall, 1'b0, none);
            prev_rise = rise;
            prev_fall = fall;
        end
    endtask

    edge_row_t rows [] = '{
        '{16'sd0, 16'sd0, 1'b1, '{16'sd0, 1'b0, 14'd0, 1'b0}},
        '{16'sd0, 16'sd0, 1'b0, '{default: '0}},
        '{16'sd400, 16'sd200, 1'b0, '{default: '0}},
        '{16'sd400, 16'sd200, 1'b0, '{default: '0}},
        '{16'sd300, 16'sd300, 1'b0, '{default: '0}},
        '{16'sd25736, -16'sd25736, 1'b0, '{default: '0}},
        '{-16'sd25736, 16'sd25736, 1'b0, '{default: '0}},
        '{16'sd1, -16'sd1, 1'b0, '{default: '0}},
        '{16'sd12868, 16'sd0, 1'b0, '{default: '0}},
        '{16'sd0, -16'sd12868, 1'b0, '{default: '0}},
        '{16'sh7FFF, 16'sh8000, 1'b0, '{default: '0}},
        '{16'sh8000, 16'sh7FFF, 1'b0, '{default: '0}},
        '{16'shFFFF, 16'shFFFF, 1'b0, '{default: '0}},
        '{16'sd5000, 16'sd4800, 1'b0, '{default: '0}},
        '{16'sd5100, 16'sd4900, 1'b0, '{default: '0}},
        '{16'sd5000, 16'sd4990, 1'b0, '{default: '0}},
        '{16'sd5010, 16'sd5000, 1'b0, '{default: '0}},
        '{-16'sd9000, -16'sd9600, 1'b0, '{default: '0}},
        '{-16'sd9100, -16'sd9500, 1'b0, '{default: '0}}
    };

    initial begin
        errors = 0;
        idle_cycles = 0;
        hold_off = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        row_typed = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        reset_tracker();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (rows[i]) begin
            send_edges(rows[i].rise, rows[i].fall, rows[i].typed, rows[i].want);
        end
        random_edges(200, 1'b1);
        drain();

        write_reg(8'(badt_pkg::REG_RADIUS), 14'd31);
        write_reg(8'(badt_pkg::REG_OUTLIER), 14'd16383);
        write_reg(8'(badt_pkg::REG_JUMP), 14'd16383);
        write_reg(8'(badt_pkg::REG_FAR), 14'd0);
        send_idle_pct = 74;
        random_edges(220, 1'b0);
        drain();

        write_reg(8'(badt_pkg::REG_RADIUS), 14'd1);
        write_reg(8'(badt_pkg::REG_OUTLIER), 14'd0);
        write_reg(8'(badt_pkg::REG_JUMP), 14'd0);
        write_reg(8'(badt_pkg::REG_FAR), 14'd16383);
        send_idle_pct = 0;
        recv_stall_pct = 74;
        random_edges(120, 1'b0);
        drain();

        // radius wider than the register, zero radius, and an unused index
        write_reg(8'(badt_pkg::REG_RADIUS), 14'd40);
        write_reg(8'(badt_pkg::REG_OUTLIER), 14'($urandom_range(16383, 2000)));
        write_reg(8'(badt_pkg::REG_JUMP), 14'($urandom_range(2000, 100)));
        write_reg(8'(badt_pkg::REG_FAR), 14'($urandom_range(4000, 1000)));
        write_reg(8'd4, 14'h3FFF);
        random_edges(100, 1'b0);
        drain();
        write_reg(8'(badt_pkg::REG_RADIUS), 14'd0);
        send_idle_pct = 27;
        recv_stall_pct = 27;
        random_edges(60, 1'b0);
        drain();
        write_reg(8'(badt_pkg::REG_RADIUS), 14'($urandom_range(31, 1)));
        random_edges(180, 1'b0);
        drain();

        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
